FILE: rtl/uer_pkg.sv
// uer_pkg: shared types and constants of the ultrasonic echo ranger
// used by uer_ctrl, uer_dp, ultrasonic_echo_ranger_top and testbench; no dependencies
`timescale 1ns / 1ps

package uer_pkg;

  localparam int unsigned TICK_W      = 16;
  localparam int unsigned TRIG_W      = 8;
  localparam int unsigned DIV_W       = 10;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 10;
  localparam int unsigned DIV_CNT_W   = $clog2(TICK_W);

  localparam logic [TRIG_W-1:0] TRIG_LEN_RST   = TRIG_W'(10);
  localparam logic [DIV_W-1:0]  TICKS_UNIT_RST = DIV_W'(2 * 58);
  localparam logic              CONT_MODE_RST  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TRIG_LEN   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_UNIT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CONT_MODE  = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2,
    PH_MEAS = 2'd3
  } uer_phase_e;

  typedef enum logic {
    CTL_RUN = 1'b0,
    CTL_DIV = 1'b1
  } uer_ctl_e;

  typedef struct packed {
    logic take;
    logic load_now;
    logic div_step;
    logic div_done;
  } uer_cmd_t;

  typedef struct packed {
    logic latch;
  } uer_sts_t;

endpackage

FILE: rtl/uer_ctrl.sv
// uer_ctrl: request handshake and divide sequencing of the echo ranger
// depends on uer_pkg
`timescale 1ns / 1ps

module uer_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  uer_pkg::uer_sts_t sts_i,
  output uer_pkg::uer_cmd_t cmd_o
);

  uer_pkg::uer_ctl_e st_q, st_d;
  logic [uer_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic take;

  localparam logic [uer_pkg::DIV_CNT_W-1:0] CNT_LAST = uer_pkg::DIV_CNT_W'(uer_pkg::TICK_W - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= uer_pkg::CTL_RUN;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (st_q == uer_pkg::CTL_RUN) && (!out_valid_q || out_ready_i);
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    st_d           = st_q;
    cnt_d          = cnt_q;
    cmd_o          = '0;
    cmd_o.take     = take;
    out_valid_d    = out_valid_q && !out_ready_i;
    unique case (st_q)
      uer_pkg::CTL_RUN: begin
        if (take) begin
          if (sts_i.latch) begin
            st_d  = uer_pkg::CTL_DIV;
            cnt_d = '0;
          end else begin
            cmd_o.load_now = 1'b1;
            out_valid_d    = 1'b1;
          end
        end
      end
      uer_pkg::CTL_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          cmd_o.div_done = 1'b1;
          out_valid_d    = 1'b1;
          st_d           = uer_pkg::CTL_RUN;
        end
      end
      default: st_d = uer_pkg::CTL_RUN;
    endcase
  end

  a_no_take_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == uer_pkg::CTL_DIV |-> !in_ready_o)
    else $error("request taken during divide");

  a_latch_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && sts_i.latch |=> st_q == uer_pkg::CTL_DIV && cnt_q == '0)
    else $error("latch did not start divide");

  a_done_gives_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_done |=> out_valid_q && st_q == uer_pkg::CTL_RUN)
    else $error("divide end did not present result");

  a_div_empty_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == uer_pkg::CTL_DIV |-> !out_valid_q)
    else $error("result pending during divide");

endmodule

FILE: rtl/uer_dp.sv
// uer_dp: sensor phase, tick counter, config registers, serial divider, result register
// depends on uer_pkg
`timescale 1ns / 1ps

module uer_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [uer_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [uer_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              echo_level_i,
  input  logic                              start_request_i,
  input  uer_pkg::uer_cmd_t                 cmd_i,
  output uer_pkg::uer_sts_t                 sts_o,
  output logic                              pin_drive_high_o,
  output logic                              pin_is_output_o,
  output logic                              busy_res_o,
  output logic                              measurement_done_o,
  output logic [uer_pkg::TICK_W-1:0]        echo_ticks_o,
  output logic [uer_pkg::TICK_W-1:0]        distance_cm_o
);

  localparam int unsigned TW = uer_pkg::TICK_W;
  localparam int unsigned DW = uer_pkg::DIV_W;

  logic [uer_pkg::TRIG_W-1:0] trig_len_q;
  logic [DW-1:0]              tpu_q;
  logic                       cont_q;

  uer_pkg::uer_phase_e phase_q, phase_d;
  logic [TW-1:0] cnt_q, cnt_d, cnt_inc;
  logic          prev_q;
  logic [TW-1:0] ticks_q, ticks_d;
  logic [TW-1:0] dist_q;
  logic          latch;
  logic [uer_pkg::TRIG_W-1:0] len;

  logic [DW-1:0] rem_q;
  logic [TW-1:0] quo_q;
  logic [DW:0]   shifted;
  logic          ge;
  logic [DW:0]   diff;
  logic [TW-1:0] quo_nx;

  logic          drive_q, busy_q, done_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_len_q <= uer_pkg::TRIG_LEN_RST;
      tpu_q      <= uer_pkg::TICKS_UNIT_RST;
      cont_q     <= uer_pkg::CONT_MODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        uer_pkg::REG_TRIG_LEN:   trig_len_q <= cfg_wdata_i[uer_pkg::TRIG_W-1:0];
        uer_pkg::REG_TICKS_UNIT: tpu_q      <= cfg_wdata_i[DW-1:0];
        uer_pkg::REG_CONT_MODE:  cont_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // sensor phase next state
  assign len     = (trig_len_q == '0) ? uer_pkg::TRIG_W'(1) : trig_len_q;
  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    ticks_d = ticks_q;
    latch   = 1'b0;
    unique case (phase_q)
      uer_pkg::PH_IDLE: begin
        if (start_request_i || cont_q) begin
          phase_d = uer_pkg::PH_TRIG;
          cnt_d   = TW'(1);
        end
      end
      uer_pkg::PH_TRIG: begin
        if (cnt_q >= TW'(len)) begin
          phase_d = uer_pkg::PH_WAIT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      uer_pkg::PH_WAIT: begin
        if (!prev_q && echo_level_i) begin
          phase_d = uer_pkg::PH_MEAS;
          cnt_d   = '0;
        end
      end
      uer_pkg::PH_MEAS: begin
        cnt_d = cnt_inc;
        if (prev_q && !echo_level_i) begin
          latch   = 1'b1;
          ticks_d = cnt_inc;
          phase_d = uer_pkg::PH_IDLE;
        end
      end
      default: phase_d = uer_pkg::PH_IDLE;
    endcase
  end

  assign sts_o.latch = latch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= uer_pkg::PH_IDLE;
      cnt_q   <= '0;
      prev_q  <= 1'b0;
      ticks_q <= '0;
    end else if (cmd_i.take) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      prev_q  <= echo_level_i;
      ticks_q <= ticks_d;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign shifted = {rem_q, quo_q[TW-1]};
  assign diff    = shifted - {1'b0, tpu_q};
  assign ge      = shifted >= {1'b0, tpu_q};
  assign quo_nx  = {quo_q[TW-2:0], ge};

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      rem_q <= '0;
      quo_q <= ticks_d;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo_q <= quo_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= '0;
    end else if (cmd_i.div_done) begin
      dist_q <= quo_nx;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_now) begin
      drive_q       <= (phase_d == uer_pkg::PH_TRIG);
      busy_q        <= (phase_d != uer_pkg::PH_IDLE);
      done_q        <= 1'b0;
      echo_ticks_o  <= ticks_q;
      distance_cm_o <= dist_q;
    end else if (cmd_i.div_done) begin
      drive_q       <= (phase_q == uer_pkg::PH_TRIG);
      busy_q        <= (phase_q != uer_pkg::PH_IDLE);
      done_q        <= 1'b1;
      echo_ticks_o  <= ticks_q;
      distance_cm_o <= quo_nx;
    end
  end

  assign pin_drive_high_o   = drive_q;
  assign pin_is_output_o    = drive_q;
  assign busy_res_o         = busy_q;
  assign measurement_done_o = done_q;

  a_latch_only_meas: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch |-> phase_q == uer_pkg::PH_MEAS && prev_q && !echo_level_i)
    else $error("latch outside measuring phase");

  a_latch_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take && latch |=> phase_q == uer_pkg::PH_IDLE)
    else $error("latch did not return to idle");

  a_trig_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == uer_pkg::PH_TRIG |-> cnt_q != '0 && cnt_q <= TW'(len) || cnt_q <= TW'(255))
    else $error("trigger counter out of bounds");

endmodule

FILE: rtl/ultrasonic_echo_ranger_top.sv
// ultrasonic_echo_ranger_top: one request per 0.5 us tick, one result per request
// a request is answered in the cycle after acceptance; the tick that ends an echo
// runs the serial divider over all 16 quotient bits and is answered once the result is registered;
// otherwise a new request is taken every cycle while the result register drains
// asynchronous active-low reset: idle phase, zero counts, configuration registers at defaults
// depends on uer_pkg, uer_ctrl, uer_dp
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           echo_level_i,
  input  logic                           start_request_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           pin_drive_high_o,
  output logic                           pin_is_output_o,
  output logic                           busy_res_o,
  output logic                           measurement_done_o,
  output logic [uer_pkg::TICK_W-1:0]     echo_ticks_o,
  output logic [uer_pkg::TICK_W-1:0]     distance_cm_o
);

  uer_pkg::uer_cmd_t cmd;
  uer_pkg::uer_sts_t sts;

  uer_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  uer_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .echo_level_i       (echo_level_i),
    .start_request_i    (start_request_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .pin_drive_high_o   (pin_drive_high_o),
    .pin_is_output_o    (pin_is_output_o),
    .busy_res_o         (busy_res_o),
    .measurement_done_o (measurement_done_o),
    .echo_ticks_o       (echo_ticks_o),
    .distance_cm_o      (distance_cm_o)
  );

endmodule

FILE: sim/testbench.sv
// testbench: self-checking bench for ultrasonic_echo_ranger_top, one request per timer tick
// tick-level predictor of the ranging phases with random idling on both handshakes
// depends on uer_pkg and ultrasonic_echo_ranger_top
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned END_SETTLE  = 25;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned PHASE_TICKS = 200;
  localparam logic [uer_pkg::CFG_IDX_W-1:0] REG_UNUSED = uer_pkg::CFG_IDX_W'(3);

  typedef struct packed {
    logic echo;
    logic start;
    logic hold;
  } tick_req_t;

  typedef struct packed {
    logic                       pin_drive_high;
    logic                       pin_is_output;
    logic                       busy_res;
    logic                       measurement_done;
    logic [uer_pkg::TICK_W-1:0] echo_ticks;
    logic [uer_pkg::TICK_W-1:0] distance_cm;
  } reading_t;

  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           cfg_we_i        = 1'b0;
  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata_i     = '0;
  logic                           in_valid_i      = 1'b0;
  logic                           in_ready_o;
  logic                           echo_level_i    = 1'b0;
  logic                           start_request_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_ready_i     = 1'b0;
  logic                           pin_drive_high_o;
  logic                           pin_is_output_o;
  logic                           busy_res_o;
  logic                           measurement_done_o;
  logic [uer_pkg::TICK_W-1:0]     echo_ticks_o;
  logic [uer_pkg::TICK_W-1:0]     distance_cm_o;

  // predictor copy of configuration and state
  logic [uer_pkg::TRIG_W-1:0] trig_len  = uer_pkg::TRIG_LEN_RST;
  logic [uer_pkg::DIV_W-1:0]  unit_div  = uer_pkg::TICKS_UNIT_RST;
  logic                       cont_mode = uer_pkg::CONT_MODE_RST;
  uer_pkg::uer_phase_e        rng_phase = uer_pkg::PH_IDLE;
  logic [uer_pkg::TICK_W-1:0] rng_count = '0;
  logic                       rng_prev  = 1'b0;
  logic [uer_pkg::TICK_W-1:0] rng_ticks = '0;
  logic [uer_pkg::TICK_W-1:0] rng_dist  = '0;

  tick_req_t   pending_ticks[$];
  reading_t    reading_q[$];
  tick_req_t   next_tick;
  reading_t    want;
  logic        steady       = 1'b0;
  int unsigned tx_gap       = 0;
  int unsigned rx_gap       = 0;
  int unsigned queued       = 0;
  int unsigned n_err        = 0;
  int unsigned stall_cycles = 0;

  ultrasonic_echo_ranger_top u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .echo_level_i       (echo_level_i),
    .start_request_i    (start_request_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .pin_drive_high_o   (pin_drive_high_o),
    .pin_is_output_o    (pin_is_output_o),
    .busy_res_o         (busy_res_o),
    .measurement_done_o (measurement_done_o),
    .echo_ticks_o       (echo_ticks_o),
    .distance_cm_o      (distance_cm_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int unsigned draw_gap();
    return steady ? 0 : $urandom_range(0, 9);
  endfunction

  // one timer tick of the ranger, queues the reading it produces
  function automatic void advance_ranger(input logic echo, input logic start);
    logic [uer_pkg::TRIG_W-1:0] len;
    reading_t                   r;
    len = (trig_len == '0) ? uer_pkg::TRIG_W'(1) : trig_len;
    r = '0;
    case (rng_phase)
      uer_pkg::PH_IDLE: begin
        if (start || cont_mode) begin
          rng_phase = uer_pkg::PH_TRIG;
          rng_count = uer_pkg::TICK_W'(1);
        end
      end
      uer_pkg::PH_TRIG: begin
        if (rng_count >= len) begin
          rng_phase = uer_pkg::PH_WAIT;
          rng_count = '0;
        end else begin
          rng_count = rng_count + 1'b1;
        end
      end
      uer_pkg::PH_WAIT: begin
        if (!rng_prev && echo) begin
          rng_phase = uer_pkg::PH_MEAS;
          rng_count = '0;
        end
      end
      default: begin
        if (rng_count != '1) rng_count = rng_count + 1'b1;
        if (rng_prev && !echo) begin
          rng_ticks = rng_count;
          rng_dist  = (unit_div == '0) ? '1 : rng_count / unit_div;
          r.measurement_done = 1'b1;
          rng_phase = uer_pkg::PH_IDLE;
        end
      end
    endcase
    rng_prev = echo;
    r.pin_drive_high = (rng_phase == uer_pkg::PH_TRIG);
    r.pin_is_output  = (rng_phase == uer_pkg::PH_TRIG);
    r.busy_res       = (rng_phase != uer_pkg::PH_IDLE);
    r.echo_ticks     = rng_ticks;
    r.distance_cm    = rng_dist;
    reading_q.push_back(r);
  endfunction

  task automatic check_field(input string name, input logic [uer_pkg::TICK_W-1:0] exp_v,
                             input logic [uer_pkg::TICK_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_err++;
    end
  endtask

  task automatic push_ticks(input logic echo, input int unsigned count, input logic start,
                            input logic hold);
    tick_req_t t;
    for (int unsigned i = 0; i < count; i++) begin
      t.echo  = echo;
      t.start = (i == 0) ? start : 1'b0;
      t.hold  = (i == 0) ? hold : 1'b0;
      pending_ticks.push_back(t);
      queued++;
    end
  endtask

  task automatic write_reg(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
                           input logic [uer_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      uer_pkg::REG_TRIG_LEN:   trig_len  = data[uer_pkg::TRIG_W-1:0];
      uer_pkg::REG_TICKS_UNIT: unit_div  = data[uer_pkg::DIV_W-1:0];
      uer_pkg::REG_CONT_MODE:  cont_mode = data[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_ticks.size() != 0 || in_valid_i || reading_q.size() != 0)
      @(negedge clk_i);
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) advance_ranger(echo_level_i, start_request_i);
    if (!in_valid_i || in_ready_o) begin
      if (tx_gap != 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_ticks.size() != 0 &&
                   !(pending_ticks[0].hold && reading_q.size() != 0)) begin
        next_tick = pending_ticks.pop_front();
        in_valid_i      <= 1'b1;
        echo_level_i    <= next_tick.echo;
        start_request_i <= next_tick.start;
        tx_gap = draw_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (reading_q.size() == 0) begin
        $error("result with nothing expected");
        n_err++;
      end else begin
        want = reading_q.pop_front();
        check_field("pin_drive_high", uer_pkg::TICK_W'(want.pin_drive_high),
                    uer_pkg::TICK_W'(pin_drive_high_o));
        check_field("pin_is_output", uer_pkg::TICK_W'(want.pin_is_output),
                    uer_pkg::TICK_W'(pin_is_output_o));
        check_field("busy_res", uer_pkg::TICK_W'(want.busy_res),
                    uer_pkg::TICK_W'(busy_res_o));
        check_field("measurement_done", uer_pkg::TICK_W'(want.measurement_done),
                    uer_pkg::TICK_W'(measurement_done_o));
        check_field("echo_ticks", want.echo_ticks, echo_ticks_o);
        check_field("distance_cm", want.distance_cm, distance_cm_o);
      end
      rx_gap = draw_gap();
    end else if (rx_gap != 0) begin
      rx_gap--;
    end
    out_ready_i <= (rx_gap == 0);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stim
    logic [uer_pkg::TRIG_W-1:0] trig;
    logic [uer_pkg::DIV_W-1:0]  unit;
    logic                       cont;
    int unsigned                eff;
    int unsigned                first;
    int unsigned                p;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero trigger length, zero divisor, echo high at release, start while busy
    write_reg(uer_pkg::REG_TRIG_LEN, '0);
    write_reg(uer_pkg::REG_TICKS_UNIT, '0);
    write_reg(uer_pkg::REG_CONT_MODE, '0);
    write_reg(REG_UNUSED, uer_pkg::CFG_DATA_W'(10'h2a5));
    push_ticks(1'b1, 1, 1'b0, 1'b0);
    push_ticks(1'b1, 1, 1'b1, 1'b0);
    push_ticks(1'b1, 2, 1'b0, 1'b0);
    push_ticks(1'b0, 1, 1'b0, 1'b0);
    push_ticks(1'b1, 1, 1'b1, 1'b0);
    push_ticks(1'b1, 1, 1'b0, 1'b0);
    push_ticks(1'b0, 2, 1'b0, 1'b0);
    wait_drained();

    // masked writes, edges while driving, shortest echo, max divisor
    write_reg(uer_pkg::REG_TRIG_LEN, uer_pkg::CFG_DATA_W'(10'h303));
    write_reg(uer_pkg::REG_TICKS_UNIT, uer_pkg::CFG_DATA_W'(1023));
    write_reg(uer_pkg::REG_CONT_MODE, uer_pkg::CFG_DATA_W'(10'h3fe));
    push_ticks(1'b0, 1, 1'b1, 1'b0);
    push_ticks(1'b1, 1, 1'b0, 1'b0);
    push_ticks(1'b0, 1, 1'b0, 1'b0);
    push_ticks(1'b1, 1, 1'b0, 1'b0);
    push_ticks(1'b0, 1, 1'b0, 1'b0);
    push_ticks(1'b1, 1, 1'b0, 1'b0);
    push_ticks(1'b0, 1, 1'b0, 1'b0);
    push_ticks(1'b0, 1, 1'b1, 1'b1);
    push_ticks(1'b0, 3, 1'b0, 1'b0);
    push_ticks(1'b1, 2, 1'b0, 1'b0);
    push_ticks(1'b0, 1, 1'b0, 1'b0);
    wait_drained();

    for (p = 0; p < RAND_PHASES; p++) begin
      trig = (p == 0) ? uer_pkg::TRIG_W'(255) : (p == 1) ? uer_pkg::TRIG_W'(1) :
             uer_pkg::TRIG_W'($urandom_range(0, 24));
      unit = (p == 2) ? uer_pkg::DIV_W'(1) : (p == 3) ? uer_pkg::DIV_W'(1023) :
             (p == 5) ? uer_pkg::DIV_W'(0) : uer_pkg::DIV_W'($urandom_range(1, 200));
      cont = (p == 0) ? 1'b1 : (p == 1) ? 1'b0 : 1'($urandom_range(0, 1));
      steady = (p == 4 || p == 7);
      write_reg(uer_pkg::REG_TRIG_LEN, {2'($urandom), trig});
      write_reg(uer_pkg::REG_TICKS_UNIT, unit);
      write_reg(uer_pkg::REG_CONT_MODE, {9'($urandom), cont});
      if (p % 3 == 0) write_reg(REG_UNUSED, uer_pkg::CFG_DATA_W'($urandom));
      eff = (trig == '0) ? 1 : trig;
      first = queued;
      while (queued - first < PHASE_TICKS) begin
        if ($urandom_range(0, 4) != 0) begin
          push_ticks(1'b0, 1, 1'b1, $urandom_range(0, 7) == 0);
          push_ticks(1'b0, $urandom_range(0, eff + 6), 1'b0, 1'b0);
          push_ticks(1'b1, ($urandom_range(0, 5) == 0) ? $urandom_range(100, 400) :
                     $urandom_range(1, 40), 1'b0, 1'b0);
          push_ticks(1'b0, $urandom_range(1, 3), 1'b0, 1'b0);
        end else begin
          repeat ($urandom_range(1, 20))
            push_ticks(1'($urandom_range(0, 1)), 1, 1'($urandom_range(0, 1)), 1'b0);
        end
      end
      wait_drained();
    end

    repeat (END_SETTLE) @(posedge clk_i);
    if (n_err == 0 && reading_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/uer_pkg.sv
rtl/uer_ctrl.sv
rtl/uer_dp.sv
rtl/ultrasonic_echo_ranger_top.sv
sim/testbench.sv
